// ===== src/mqtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqtd_pkg
// Shared types and codes of the multi-queue task dispatcher.
// ----------------------------------------------------------------------------
package mqtd_pkg;

    // Request action codes as they arrive on the input channel
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_TAKE = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_INIT   = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    // Dispatch policies (any other code acts as round robin)
    localparam logic [1:0] POLICY_RR    = 2'd0;
    localparam logic [1:0] POLICY_RAND  = 2'd1;
    localparam logic [1:0] POLICY_LEAST = 2'd2;

    // Galois LFSR
    localparam int          LFSR_W    = 16;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Register reset values
    localparam logic [1:0] RST_POLICY = 2'd0;
    localparam logic [3:0] RST_INIT   = 4'd1;
    localparam logic [3:0] RST_LIMIT  = 4'd8;

    // Classified operation
    typedef enum logic [1:0] {
        OP_ADD,
        OP_TAKE,
        OP_TICK,
        OP_NONE
    } t_op;

    // Request held in the queue between front and back
    typedef struct packed {
        t_op         op;
        logic [15:0] task_id;
        logic [2:0]  queue_index;
    } t_req;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE_RD,
        S_BAL_SCAN,
        S_BAL_POP,
        S_BAL_PUSH,
        S_PICK,
        S_RND_MOD,
        S_LL_SCAN,
        S_RR_TRY,
        S_PUSH
    } t_state;

endpackage
`default_nettype wire

// ===== src/mqtd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqtd_front
// Accepts requests, classifies the action and holds them in a two-entry queue
// for the back end.
// ----------------------------------------------------------------------------
module mqtd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [1:0]      i_action,
    input  wire logic [15:0]     i_task_id,
    input  wire logic [2:0]      i_queue_index,
    output logic                 o_req_valid,
    output mqtd_pkg::t_req       o_req,
    input  wire logic            i_req_pop
);

    mqtd_pkg::t_req r_fifo [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    mqtd_pkg::t_req w_req;
    logic           w_push;

    // classify the incoming action
    always_comb begin
        w_req.task_id     = i_task_id;
        w_req.queue_index = i_queue_index;
        unique case (i_action)
            mqtd_pkg::ACT_ADD:  w_req.op = mqtd_pkg::OP_ADD;
            mqtd_pkg::ACT_TAKE: w_req.op = mqtd_pkg::OP_TAKE;
            mqtd_pkg::ACT_TICK: w_req.op = mqtd_pkg::OP_TICK;
            default:            w_req.op = mqtd_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_fifo[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_req;
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_req_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, i_req_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/mqtd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqtd_back
// Executes requests: owns the ring queues, the task store, the dispatch
// policies, the rebalance sequence, the configuration registers and the
// result register.
// ----------------------------------------------------------------------------
module mqtd_back #(
    parameter int MAX_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_WIDTH  = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  mqtd_pkg::t_req       i_req,
    output logic                 o_req_pop,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [3:0]      i_cfg_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [1:0]           o_status,
    output logic [2:0]           o_queue_used,
    output logic [15:0]          o_task_out,
    output logic                 o_task_valid,
    output logic [3:0]           o_active_count
);

    localparam int QW        = $clog2(MAX_QUEUES);
    localparam int CW        = $clog2(MAX_QUEUES + 1);
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int MEM_DEPTH = MAX_QUEUES * QUEUE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SW        = (TASK_WIDTH < 16) ? TASK_WIDTH : 16;
    localparam int BW        = $clog2(mqtd_pkg::LFSR_W);

    localparam logic [PW-1:0] DEPTH_M1 = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X  = (PW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] MAXQ_CNT = CW'(MAX_QUEUES);
    localparam logic [BW-1:0] LAST_BIT = BW'(mqtd_pkg::LFSR_W - 1);

    // state and datapath registers
    mqtd_pkg::t_state r_state, n_state;
    mqtd_pkg::t_req   r_req, n_req;
    logic [CW-1:0]    r_cur, n_cur;
    logic [QW-1:0]    r_lo, n_lo, r_hi, n_hi, r_q, n_q, r_rr, n_rr;
    logic [PW-1:0]    r_lo_n, n_lo_n, r_hi_n, n_hi_n, r_moves, n_moves, r_best, n_best;
    logic [15:0]      r_lfsr, n_lfsr, r_div, n_div;
    logic [CW-1:0]    r_rem, n_rem;
    logic [BW-1:0]    r_bit, n_bit;
    logic [CW-1:0]    r_active, n_active;
    logic             r_pend, n_pend;
    logic [1:0]       r_policy, n_policy;
    logic [3:0]       r_init, n_init;
    logic [3:0]       r_limit, n_limit;
    logic [PW-1:0]    r_wp [MAX_QUEUES];
    logic [PW-1:0]    r_rp [MAX_QUEUES];
    logic [SW-1:0]    r_mem [MEM_DEPTH];
    logic [SW-1:0]    r_rd;

    // result register
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [2:0]       r_out_used;
    logic [15:0]      r_out_task;
    logic             r_out_tvalid;
    logic [3:0]       r_out_active;

    // control strobes
    logic [QW-1:0]    sel;
    logic             wp_we, rp_we, mem_we, mem_re, cfg_grow, out_load, req_pop;
    logic [PW-1:0]    wp_new, rp_new, mem_ptr;
    logic [SW-1:0]    mem_wdata;
    logic [1:0]       out_status;
    logic [QW-1:0]    out_used;
    logic [SW-1:0]    out_task;
    logic             out_tvalid;

    // selected queue view
    logic [PW-1:0]    wp_s, rp_s, wp_inc, wp_dec, rp_inc, size_s;
    logic [PW:0]      diff_s;
    logic             full_s, empty_s;
    logic [AW-1:0]    mem_addr;

    // helpers
    logic             cfg_we, cur_lt_act, take_bad;
    logic [CW-1:0]    cfg_cnt, limit_cnt, rr_mod;
    logic [CW:0]      rr_rem, div_tmp;
    logic [PW-1:0]    moves_calc;
    logic [15:0]      lfsr_step;

    assign cfg_we     = i_cfg_valid && o_cfg_ready;
    assign cur_lt_act = (r_cur < r_active);
    assign moves_calc = (r_hi_n - r_lo_n) >> 1;

    // clamp of configured counts to 1..MAX_QUEUES
    always_comb begin
        if (i_cfg_data == 4'd0) begin
            cfg_cnt = CW'(1);
        end else if (32'(i_cfg_data) > MAX_QUEUES) begin
            cfg_cnt = MAXQ_CNT;
        end else begin
            cfg_cnt = CW'(i_cfg_data);
        end
        if (r_limit == 4'd0) begin
            limit_cnt = CW'(1);
        end else if (32'(r_limit) > MAX_QUEUES) begin
            limit_cnt = MAXQ_CNT;
        end else begin
            limit_cnt = CW'(r_limit);
        end
    end

    // round robin pointer wrapped into a new active count, one bit a step
    always_comb begin
        rr_rem = '0;
        for (int b = QW - 1; b >= 0; b--) begin
            rr_rem = {rr_rem[CW-1:0], r_rr[b]};
            if (rr_rem >= {1'b0, cfg_cnt}) begin
                rr_rem = rr_rem - {1'b0, cfg_cnt};
            end
        end
        rr_mod = CW'(rr_rem);
    end

    // LFSR advance and one restoring step of the modulo
    always_comb begin
        lfsr_step = r_lfsr >> 1;
        if (r_lfsr[0]) begin
            lfsr_step = lfsr_step ^ mqtd_pkg::LFSR_TAPS;
        end
        div_tmp = {r_rem, r_div[15]};
        if (div_tmp >= {1'b0, r_active}) begin
            div_tmp = div_tmp - {1'b0, r_active};
        end
    end

    // queue selected this cycle
    always_comb begin
        unique case (r_state)
            mqtd_pkg::S_DECODE:   sel = QW'(r_req.queue_index);
            mqtd_pkg::S_TAKE_RD:  sel = QW'(r_req.queue_index);
            mqtd_pkg::S_BAL_POP:  sel = r_hi;
            mqtd_pkg::S_BAL_PUSH: sel = r_lo;
            mqtd_pkg::S_PUSH:     sel = r_q;
            mqtd_pkg::S_RR_TRY:   sel = cur_lt_act ? r_rr : QW'(r_active);
            default:              sel = QW'(r_cur);
        endcase
    end

    // pointers, fill and address of the selected queue
    always_comb begin
        wp_s    = r_wp[sel];
        rp_s    = r_rp[sel];
        wp_inc  = (wp_s == DEPTH_M1) ? '0 : wp_s + PW'(1);
        rp_inc  = (rp_s == DEPTH_M1) ? '0 : rp_s + PW'(1);
        wp_dec  = (wp_s == '0) ? DEPTH_M1 : wp_s - PW'(1);
        diff_s  = {1'b0, wp_s} + ((wp_s >= rp_s) ? '0 : DEPTH_X) - {1'b0, rp_s};
        size_s  = PW'(diff_s);
        full_s  = (wp_inc == rp_s);
        empty_s = (wp_s == rp_s);
        take_bad = (32'(r_req.queue_index) >= 32'(r_active)) ||
                   (32'(r_req.queue_index) >= MAX_QUEUES) || empty_s;
    end

    assign mem_addr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(mem_ptr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mqtd_pkg::S_IDLE: begin
                if (i_req_valid && !r_out_valid) n_state = mqtd_pkg::S_DECODE;
            end
            mqtd_pkg::S_DECODE: begin
                case (r_req.op)
                    mqtd_pkg::OP_TAKE:
                        n_state = take_bad ? mqtd_pkg::S_IDLE : mqtd_pkg::S_TAKE_RD;
                    mqtd_pkg::OP_ADD:
                        n_state = r_pend ? mqtd_pkg::S_BAL_SCAN : mqtd_pkg::S_PICK;
                    default:
                        n_state = mqtd_pkg::S_IDLE;
                endcase
            end
            mqtd_pkg::S_TAKE_RD: n_state = mqtd_pkg::S_IDLE;
            mqtd_pkg::S_BAL_SCAN: begin
                if (!cur_lt_act) begin
                    n_state = (moves_calc == '0) ? mqtd_pkg::S_PICK : mqtd_pkg::S_BAL_POP;
                end
            end
            mqtd_pkg::S_BAL_POP: n_state = mqtd_pkg::S_BAL_PUSH;
            mqtd_pkg::S_BAL_PUSH: begin
                n_state = (r_moves == PW'(1)) ? mqtd_pkg::S_PICK : mqtd_pkg::S_BAL_POP;
            end
            mqtd_pkg::S_PICK: begin
                case (r_policy)
                    mqtd_pkg::POLICY_RAND:  n_state = mqtd_pkg::S_RND_MOD;
                    mqtd_pkg::POLICY_LEAST: n_state = mqtd_pkg::S_LL_SCAN;
                    default:                n_state = mqtd_pkg::S_RR_TRY;
                endcase
            end
            mqtd_pkg::S_RND_MOD: begin
                if (r_bit == LAST_BIT) n_state = mqtd_pkg::S_PUSH;
            end
            mqtd_pkg::S_LL_SCAN: begin
                if (!cur_lt_act) n_state = mqtd_pkg::S_PUSH;
            end
            mqtd_pkg::S_RR_TRY: begin
                if (!cur_lt_act || !full_s) n_state = mqtd_pkg::S_IDLE;
            end
            mqtd_pkg::S_PUSH: n_state = mqtd_pkg::S_IDLE;
            default: n_state = mqtd_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_req      = r_req;
        n_cur      = r_cur;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_lo_n     = r_lo_n;
        n_hi_n     = r_hi_n;
        n_moves    = r_moves;
        n_best     = r_best;
        n_q        = r_q;
        n_rr       = r_rr;
        n_lfsr     = r_lfsr;
        n_div      = r_div;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_active   = r_active;
        n_pend     = r_pend;
        n_policy   = r_policy;
        n_init     = r_init;
        n_limit    = r_limit;
        wp_we      = 1'b0;
        rp_we      = 1'b0;
        wp_new     = wp_inc;
        rp_new     = rp_inc;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_ptr    = wp_s;
        mem_wdata  = SW'(r_req.task_id);
        cfg_grow   = 1'b0;
        out_load   = 1'b0;
        out_status = mqtd_pkg::STATUS_DONE;
        out_used   = '0;
        out_task   = '0;
        out_tvalid = 1'b0;
        req_pop    = 1'b0;
        o_cfg_ready = (r_state == mqtd_pkg::S_IDLE);

        unique case (r_state)
            mqtd_pkg::S_IDLE: begin
                if (i_req_valid && !r_out_valid) begin
                    req_pop = 1'b1;
                    n_req   = i_req;
                end
                // register writes
                if (cfg_we) begin
                    case (i_cfg_index)
                        mqtd_pkg::CFG_POLICY: n_policy = i_cfg_data[1:0];
                        mqtd_pkg::CFG_INIT: begin
                            n_init   = i_cfg_data;
                            n_active = cfg_cnt;
                            n_rr     = QW'(rr_mod);
                            cfg_grow = 1'b1;
                        end
                        mqtd_pkg::CFG_LIMIT:  n_limit = i_cfg_data;
                        default: ;
                    endcase
                end
            end
            mqtd_pkg::S_DECODE: begin
                case (r_req.op)
                    mqtd_pkg::OP_TAKE: begin
                        if (take_bad) begin
                            out_load   = 1'b1;
                            out_status = mqtd_pkg::STATUS_EMPTY;
                            out_used   = QW'(r_req.queue_index);
                        end else begin
                            mem_re  = 1'b1;
                            mem_ptr = rp_s;
                            rp_we   = 1'b1;
                        end
                    end
                    mqtd_pkg::OP_ADD: begin
                        if (r_pend) begin
                            n_pend = 1'b0;
                            n_cur  = '0;
                            n_lo   = '0;
                            n_hi   = '0;
                            n_lo_n = '0;
                            n_hi_n = '0;
                        end
                    end
                    mqtd_pkg::OP_TICK: begin
                        n_pend   = 1'b1;
                        out_load = 1'b1;
                    end
                    default: out_load = 1'b1;
                endcase
            end
            mqtd_pkg::S_TAKE_RD: begin
                out_load   = 1'b1;
                out_used   = QW'(r_req.queue_index);
                out_task   = r_rd;
                out_tvalid = 1'b1;
            end
            // find the emptiest and the fullest active queue
            mqtd_pkg::S_BAL_SCAN: begin
                if (cur_lt_act) begin
                    if (r_cur == '0 || size_s < r_lo_n) begin
                        n_lo_n = size_s;
                        n_lo   = QW'(r_cur);
                    end
                    if (size_s > r_hi_n) begin
                        n_hi_n = size_s;
                        n_hi   = QW'(r_cur);
                    end
                    n_cur = r_cur + CW'(1);
                end else begin
                    n_moves = moves_calc;
                end
            end
            // take the newest task off the fullest queue
            mqtd_pkg::S_BAL_POP: begin
                wp_we   = 1'b1;
                wp_new  = wp_dec;
                mem_re  = 1'b1;
                mem_ptr = wp_dec;
            end
            // and append it to the emptiest one
            mqtd_pkg::S_BAL_PUSH: begin
                if (!full_s) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd;
                    wp_we     = 1'b1;
                end
                n_moves = r_moves - PW'(1);
            end
            mqtd_pkg::S_PICK: begin
                n_cur  = '0;
                n_best = '0;
                n_q    = '0;
                if (r_policy == mqtd_pkg::POLICY_RAND) begin
                    n_lfsr = lfsr_step;
                    n_div  = lfsr_step;
                    n_rem  = '0;
                    n_bit  = '0;
                end
            end
            // LFSR value modulo the active count, one bit a cycle
            mqtd_pkg::S_RND_MOD: begin
                n_rem = CW'(div_tmp);
                n_div = r_div << 1;
                n_bit = r_bit + BW'(1);
                if (r_bit == LAST_BIT) n_q = QW'(div_tmp);
            end
            // least occupied queue, first on a tie
            mqtd_pkg::S_LL_SCAN: begin
                if (cur_lt_act) begin
                    if (r_cur == '0 || size_s < r_best) begin
                        n_best = size_s;
                        n_q    = QW'(r_cur);
                    end
                    n_cur = r_cur + CW'(1);
                end
            end
            // round robin, a queue a cycle; all full: grow under limit, else FULL
            mqtd_pkg::S_RR_TRY: begin
                if (cur_lt_act) begin
                    n_rr = ((CW'(r_rr) + CW'(1)) == r_active) ? '0 : r_rr + QW'(1);
                    if (!full_s) begin
                        mem_we   = 1'b1;
                        wp_we    = 1'b1;
                        out_load = 1'b1;
                        out_used = r_rr;
                    end else begin
                        n_cur = r_cur + CW'(1);
                    end
                end else if (r_active < limit_cnt) begin
                    mem_we   = 1'b1;
                    mem_ptr  = '0;
                    wp_we    = 1'b1;
                    wp_new   = PW'(1);
                    rp_we    = 1'b1;
                    rp_new   = '0;
                    n_active = r_active + CW'(1);
                    n_rr     = '0;
                    out_load = 1'b1;
                    out_used = QW'(r_active);
                end else begin
                    out_load   = 1'b1;
                    out_status = mqtd_pkg::STATUS_FULL;
                end
            end
            mqtd_pkg::S_PUSH: begin
                out_load = 1'b1;
                if (full_s) begin
                    out_status = mqtd_pkg::STATUS_FULL;
                end else begin
                    mem_we   = 1'b1;
                    wp_we    = 1'b1;
                    out_used = r_q;
                end
            end
            default: ;
        endcase
    end

    assign o_req_pop = req_pop;

    // task store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    // ring pointers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_QUEUES; i++) begin
            if (!i_rst_n) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end else if (cfg_grow && 32'(r_active) <= i && i < 32'(n_active)) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end else if (32'(sel) == i) begin
                if (wp_we) r_wp[i] <= wp_new;
                if (rp_we) r_rp[i] <= rp_new;
            end
        end
    end

    // sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mqtd_pkg::S_IDLE;
            r_active <= CW'(mqtd_pkg::RST_INIT);
            r_rr     <= '0;
            r_lfsr   <= mqtd_pkg::LFSR_SEED;
            r_pend   <= 1'b0;
            r_policy <= mqtd_pkg::RST_POLICY;
            r_init   <= mqtd_pkg::RST_INIT;
            r_limit  <= mqtd_pkg::RST_LIMIT;
            r_cur    <= '0;
            r_moves  <= '0;
            r_bit    <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_rr     <= n_rr;
            r_lfsr   <= n_lfsr;
            r_pend   <= n_pend;
            r_policy <= n_policy;
            r_init   <= n_init;
            r_limit  <= n_limit;
            r_cur    <= n_cur;
            r_moves  <= n_moves;
            r_bit    <= n_bit;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_lo_n <= n_lo_n;
        r_hi_n <= n_hi_n;
        r_best <= n_best;
        r_q    <= n_q;
        r_div  <= n_div;
        r_rem  <= n_rem;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= out_status;
            r_out_used   <= 3'(out_used);
            r_out_task   <= 16'(out_task);
            r_out_tvalid <= out_tvalid;
            r_out_active <= 4'(n_active);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_queue_used   = r_out_used;
    assign o_task_out     = r_out_task;
    assign o_task_valid   = r_out_tvalid;
    assign o_active_count = r_out_active;

endmodule
`default_nettype wire

// ===== src/multi_queue_task_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_task_dispatcher
// Places task ids into worker ring queues by round robin, LFSR pick or least
// load, pops them for workers and rebalances on request.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        i_in_valid/o_in_stall  i_action, i_task_id, i_queue_index
//  out       o_out_valid/i_out_stall o_status, o_queue_used, o_task_out,
//                                   o_task_valid, o_active_count
//  cfg       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A tick marks a rebalance that runs at the start of the next add. The
// back-end sequencer handles one request at a time; the two-entry front
// queue keeps accepting while it works or while a result waits, stalling
// the input only when both entries are held.
// Synchronous active-low reset; the task store is not cleared.
// ----------------------------------------------------------------------------
module multi_queue_task_dispatcher #(
    parameter int MAX_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_WIDTH  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_task_id,
    input  wire logic [2:0]  i_queue_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_queue_used,
    output logic [15:0]      o_task_out,
    output logic             o_task_valid,
    output logic [3:0]       o_active_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    logic           req_valid;
    logic           req_pop;
    mqtd_pkg::t_req req;

    // request classification and queue
    mqtd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_task_id     (i_task_id),
        .i_queue_index (i_queue_index),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .i_req_pop     (req_pop)
    );

    // dispatch engine
    mqtd_back #(
        .MAX_QUEUES  (MAX_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_WIDTH  (TASK_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .o_req_pop      (req_pop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_queue_used   (o_queue_used),
        .o_task_out     (o_task_out),
        .o_task_valid   (o_task_valid),
        .o_active_count (o_active_count)
    );

endmodule
`default_nettype wire
